// ===== rtl/mar_pkg.sv =====
// ----------------------------------------------------------------------------
// mar_pkg: shared types and constants of the modulo address update unit
// Holds the command codes, the register word types and the item layout.
// ----------------------------------------------------------------------------
package mar_pkg;

  // Register file geometry.
  localparam int NumRegs = 4;
  localparam int SelW    = 2;
  localparam int WordW   = 16;
  localparam int ExtW    = WordW + 1;

  // Configuration port geometry.
  localparam int AddrW = 4;
  localparam int DataW = 32;

  // Wrap registers come out of reset as a full 64K buffer.
  localparam logic [WordW-1:0] WrapReset = 16'hFFFF;

  // Bound below which an inverted subtract index counts as an upward step.
  localparam logic [ExtW-1:0] MinNegThreshold = 17'h07FFF;

  typedef logic [WordW-1:0] word_t;
  typedef logic [ExtW-1:0]  ext_t;
  typedef logic [SelW-1:0]  sel_t;
  typedef word_t [NumRegs-1:0] wrap_arr_t;

  typedef enum logic [2:0] {
    CmdIncrement  = 3'd0,
    CmdDecrement  = 3'd1,
    CmdAddIndex   = 3'd2,
    CmdSubIndex   = 3'd3,
    CmdLoadAddr   = 3'd4,
    CmdLoadIndex  = 3'd5
  } cmd_t;

  // One command item as held in the input register.
  typedef struct packed {
    cmd_t  cmd;
    sel_t  addr_select;
    sel_t  index_select;
    word_t load_value;
  } item_t;

endpackage

// ===== rtl/mar_cfg.sv =====
// ----------------------------------------------------------------------------
// mar_cfg: wrap register bank behind the APB-style configuration port
// Four 16-bit wrap registers at byte addresses 0, 4, 8 and 12.
// ----------------------------------------------------------------------------
module mar_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mar_pkg::AddrW-1:0] paddr,
  input  logic [mar_pkg::DataW-1:0] pwdata,
  output logic [mar_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output mar_pkg::wrap_arr_t        wrap
);
  import mar_pkg::*;

  sel_t reg_sel;
  logic wr_en;

  // The word address picks the register; byte offset bits are ignored.
  assign reg_sel = paddr[AddrW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register bank.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) begin
        wrap[i] <= WrapReset;
      end
    end else if (wr_en) begin
      wrap[reg_sel] <= pwdata[WordW-1:0];
    end
  end

  // Read data is zero-extended to the bus width.
  assign prdata = {{(DataW - WordW){1'b0}}, wrap[reg_sel]};

endmodule

// ===== rtl/mar_alu.sv =====
// ----------------------------------------------------------------------------
// mar_alu: modulo address arithmetic
// Computes the new address register value for one command, wrapping steps
// inside the modulo buffer by watching the carry just above the wrap mask.
// ----------------------------------------------------------------------------
module mar_alu (
  input  mar_pkg::item_t item,
  input  mar_pkg::word_t ar,
  input  mar_pkg::word_t wr,
  input  mar_pkg::word_t ix,
  output mar_pkg::word_t new_ar
);
  import mar_pkg::*;

  // All checks touch only the low 17 bits, so 17-bit arithmetic is exact.
  function automatic ext_t wrap_mask(word_t w);
    return {w[WordW-1:1], 1'b1, 1'b0};
  endfunction

  function automatic ext_t sext(word_t v);
    return {v[WordW-1], v};
  endfunction

  function automatic word_t modulo_add(word_t a, word_t w, ext_t step, ext_t xterm,
                                       logic upward);
    ext_t nar;
    ext_t dar;
    ext_t w1;
    nar = {1'b0, a} + step;
    dar = (nar ^ {1'b0, a} ^ xterm) & wrap_mask(w);
    w1  = {1'b0, w} + ext_t'(1);
    if (upward) begin
      if (dar > {1'b0, w}) nar = nar - w1;
    end else begin
      if ((((nar + w1) ^ nar) & dar) <= {1'b0, w}) nar = nar + w1;
    end
    return nar[WordW-1:0];
  endfunction

  function automatic word_t step_up(word_t a, word_t w);
    ext_t nar;
    nar = {1'b0, a} + ext_t'(1);
    if ((nar ^ {1'b0, a}) > wrap_mask(w)) nar = nar - ({1'b0, w} + ext_t'(1));
    return nar[WordW-1:0];
  endfunction

  function automatic word_t step_down(word_t a, word_t w);
    ext_t nar;
    nar = {1'b0, a} + {1'b0, w};
    if (((nar ^ {1'b0, a}) & wrap_mask(w)) > {1'b0, w}) begin
      nar = nar - ({1'b0, w} + ext_t'(1));
    end
    return nar[WordW-1:0];
  endfunction

  ext_t add_step;
  ext_t sub_inv;
  ext_t sub_step;

  assign add_step = sext(ix);
  assign sub_inv  = ~sext(ix);
  assign sub_step = sub_inv + ext_t'(1);

  // Command decode; load index and unused codes leave the address alone.
  always_comb begin
    case (item.cmd)
      CmdIncrement: new_ar = step_up(ar, wr);
      CmdDecrement: new_ar = step_down(ar, wr);
      CmdAddIndex:  new_ar = modulo_add(ar, wr, add_step, add_step, !ix[WordW-1]);
      CmdSubIndex:  new_ar = modulo_add(ar, wr, sub_step, sub_inv,
                                        sub_inv < MinNegThreshold);
      CmdLoadAddr:  new_ar = item.load_value;
      default:      new_ar = ar;
    endcase
  end

endmodule

// ===== rtl/modulo_address_register_update_unit.sv =====
// ----------------------------------------------------------------------------
// modulo_address_register_update_unit: DSP modulo address generator
// Pipeline: a result passes through the input register and then the result register,
// and waits in the result register while the result channel is stalled.
// Throughput: one item per cycle while the result channel is not stalled, set by the
// single register-file update step between the input register and the result register.
// Reset: address and index registers clear to zero, wrap registers to 0xFFFF,
// and both pipeline stages empty.
// ----------------------------------------------------------------------------
module modulo_address_register_update_unit (
  input  logic                      clk,
  input  logic                      rst,
  // Configuration port.
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mar_pkg::AddrW-1:0] paddr,
  input  logic [mar_pkg::DataW-1:0] pwdata,
  output logic [mar_pkg::DataW-1:0] prdata,
  output logic                      pready,
  // Command channel.
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                command,
  input  logic [1:0]                addr_select,
  input  logic [1:0]                index_select,
  input  logic [15:0]               load_value,
  // Result channel.
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [15:0]               new_address
);
  import mar_pkg::*;

  wrap_arr_t wrap;
  word_t     address_regs [NumRegs];
  word_t     index_regs   [NumRegs];

  logic  s1_valid;
  item_t s1_item;
  logic  advance;
  sel_t  ix_sel;
  word_t cur_ar;
  word_t cur_wr;
  word_t cur_ix;
  word_t new_ar;

  mar_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .wrap    (wrap)
  );

  // Handshake: the input stage moves on whenever the result register frees up.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.cmd          <= cmd_t'(command);
      s1_item.addr_select  <= addr_select;
      s1_item.index_select <= index_select;
      s1_item.load_value   <= load_value;
    end
  end

  // Operand fetch; one index read port serves both add and subtract.
  assign ix_sel = (s1_item.cmd == CmdAddIndex) ? s1_item.index_select : s1_item.addr_select;
  assign cur_ar = address_regs[s1_item.addr_select];
  assign cur_wr = wrap[s1_item.addr_select];
  assign cur_ix = index_regs[ix_sel];

  mar_alu u_alu (
    .item   (s1_item),
    .ar     (cur_ar),
    .wr     (cur_wr),
    .ix     (cur_ix),
    .new_ar (new_ar)
  );

  // Register file update as the item leaves the input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) begin
        address_regs[i] <= '0;
        index_regs[i]   <= '0;
      end
    end else if (advance) begin
      address_regs[s1_item.addr_select] <= new_ar;
      if (s1_item.cmd == CmdLoadIndex) begin
        index_regs[s1_item.addr_select] <= s1_item.load_value;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      new_address <= new_ar;
    end
  end

endmodule
